>>> rtl/core/event_deadline_timer_table_top_macros.svh
// Assertion macros for the event deadline timer table checker
`ifndef EVENT_DEADLINE_TIMER_TABLE_TOP_MACROS_SVH
`define EVENT_DEADLINE_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define EDT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("edt checker: property failed");

// next-cycle implication, sampled on clk, off during rst
`define EDT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("edt checker: property failed");

`endif

>>> rtl/core/edt_pkg.sv
// Types and constants shared by the event deadline timer table files
`timescale 1ns / 1ps

package edt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = $clog2(SLOTS + 1);
  localparam int TIME_W = 32;
  localparam int DUR_W  = 31;
  localparam int LAZY_W = 16;
  localparam logic [LAZY_W-1:0] LAZY_RESET = 16'd300;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_DELETE,
    REQ_EXPIRE,
    REQ_NEAREST
  } req_t;

  typedef enum logic [2:0] {
    KIND_ADDED,
    KIND_KEPT,
    KIND_DELETED,
    KIND_DEL_IGNORED,
    KIND_EXPIRED,
    KIND_NONE_EXPIRED,
    KIND_NEAREST,
    KIND_NONE_ARMED
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_PUSH
  } state_t;

endpackage

>>> rtl/core/event_deadline_timer_table_top.sv
// Event deadline timer table: slot table with lazy re-arm, expiry and nearest query
// Add: ADD_CHECK, then PUSH; delete: straight to PUSH; one word in flight at a time.
// Nearest: a scan, DECIDE, PUSH; expire: one scan per expired slot plus one final scan.
// Each search reads the deadline memory through its one read port, one slot per cycle.
// A new word is taken once the previous request has queued its last result word.
// Synchronous active-high rst clears the armed flags, the control and lazy_delay to 300.
`timescale 1ns / 1ps

module event_deadline_timer_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [edt_pkg::LAZY_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [edt_pkg::SLOT_W-1:0]     slot,
  input  logic [edt_pkg::TIME_W-1:0]     now,
  input  logic [edt_pkg::DUR_W-1:0]      duration,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     kind,
  output logic [edt_pkg::SLOT_W-1:0]     slot_out,
  output logic [edt_pkg::DUR_W-1:0]      remaining,
  output logic                           last
);
  import edt_pkg::*;

  state_t              state, state_next;
  logic [LAZY_W-1:0]   lazy_delay;
  req_t                req;
  logic [SLOT_W-1:0]   req_slot;
  logic [TIME_W-1:0]   req_now;
  logic [TIME_W-1:0]   key;
  logic [SLOTS-1:0]    armed;

  logic [TIME_W-1:0]   mem [SLOTS];
  logic [TIME_W-1:0]   rd_data;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;

  logic [IDX_W-1:0]    idx;
  logic                rd_vld;
  logic [SLOT_W-1:0]   rd_idx;
  logic                best_ok;
  logic [SLOT_W-1:0]   best_slot;
  logic [TIME_W-1:0]   best_dl;
  logic                held_ok;
  logic [SLOT_W-1:0]   held_slot;

  kind_t               pend_kind;
  logic [SLOT_W-1:0]   pend_slot;
  logic [DUR_W-1:0]    pend_rem;
  logic                pend_last;
  logic                pend_rescan;

  logic                accept;
  logic                out_free;
  logic                scan_more;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W-1:0]   mag;
  logic                lazy_hit;
  logic                due;
  logic [TIME_W-1:0]   near_d;
  logic [DUR_W-1:0]    near_rem;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign scan_more = idx < IDX_W'(SLOTS);

  assign diff     = key - rd_data;
  assign mag      = diff[TIME_W-1] ? (~diff + TIME_W'(1)) : diff;
  assign lazy_hit = armed[req_slot] && (mag < TIME_W'(lazy_delay));
  assign due      = best_ok && (best_dl <= req_now);
  assign near_d   = best_dl - req_now;
  assign near_rem = (near_d != '0 && !near_d[TIME_W-1]) ? near_d[DUR_W-1:0] : '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_t'(req_type))
            REQ_ADD:    state_next = ST_ADD_CHECK;
            REQ_DELETE: state_next = ST_PUSH;
            default:    state_next = ST_SCAN;
          endcase
        end
      end
      ST_ADD_CHECK: state_next = ST_PUSH;
      ST_SCAN: begin
        if (!scan_more && !rd_vld) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (req == REQ_EXPIRE && due && !held_ok) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_next = pend_rescan ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = idx[SLOT_W-1:0];
    wr_en    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = rst;
        rd_en    = accept && (req_t'(req_type) == REQ_ADD);
        rd_addr  = slot;
      end
      ST_ADD_CHECK: wr_en = !lazy_hit;
      ST_SCAN:      rd_en = scan_more;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_slot] <= key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      lazy_delay <= LAZY_RESET;
      armed      <= '0;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      best_ok    <= 1'b0;
      held_ok    <= 1'b0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        lazy_delay <= cfg_wdata;
      end
      if (state == ST_PUSH && out_free) begin
        out_valid <= 1'b1;
        kind      <= pend_kind;
        slot_out  <= pend_slot;
        remaining <= pend_rem;
        last      <= pend_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req         <= req_t'(req_type);
            req_slot    <= slot;
            req_now     <= now;
            key         <= now + TIME_W'(duration);
            idx         <= '0;
            rd_vld      <= 1'b0;
            best_ok     <= 1'b0;
            held_ok     <= 1'b0;
            pend_slot   <= slot;
            pend_rem    <= '0;
            pend_last   <= 1'b1;
            pend_rescan <= 1'b0;
            pend_kind   <= armed[slot] ? KIND_DELETED : KIND_DEL_IGNORED;
            if (req_t'(req_type) == REQ_DELETE) begin
              armed[slot] <= 1'b0;
            end
          end
        end
        ST_ADD_CHECK: begin
          pend_kind <= lazy_hit ? KIND_KEPT : KIND_ADDED;
          if (!lazy_hit) begin
            armed[req_slot] <= 1'b1;
          end
        end
        ST_SCAN: begin
          rd_vld <= scan_more;
          rd_idx <= idx[SLOT_W-1:0];
          if (scan_more) begin
            idx <= idx + IDX_W'(1);
          end
          if (rd_vld && armed[rd_idx] && (!best_ok || rd_data < best_dl)) begin
            best_ok   <= 1'b1;
            best_slot <= rd_idx;
            best_dl   <= rd_data;
          end
        end
        ST_DECIDE: begin
          idx     <= '0;
          rd_vld  <= 1'b0;
          best_ok <= 1'b0;
          if (req == REQ_NEAREST) begin
            pend_kind   <= best_ok ? KIND_NEAREST : KIND_NONE_ARMED;
            pend_slot   <= best_ok ? best_slot : '0;
            pend_rem    <= best_ok ? near_rem : '0;
            pend_last   <= 1'b1;
            pend_rescan <= 1'b0;
          end else if (due) begin
            armed[best_slot] <= 1'b0;
            held_ok          <= 1'b1;
            held_slot        <= best_slot;
            pend_kind        <= KIND_EXPIRED;
            pend_slot        <= held_slot;
            pend_rem         <= '0;
            pend_last        <= 1'b0;
            pend_rescan      <= 1'b1;
          end else begin
            pend_kind   <= held_ok ? KIND_EXPIRED : KIND_NONE_EXPIRED;
            pend_slot   <= held_ok ? held_slot : '0;
            pend_rem    <= '0;
            pend_last   <= 1'b1;
            pend_rescan <= 1'b0;
          end
        end
        default: begin
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/edt_checker.sv
// Port-level checker for the event deadline timer table, bound to the top level
`timescale 1ns / 1ps
`include "event_deadline_timer_table_top_macros.svh"

module edt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_wen,
  input logic [edt_pkg::LAZY_W-1:0]     cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [1:0]                     req_type,
  input logic [edt_pkg::SLOT_W-1:0]     slot,
  input logic [edt_pkg::TIME_W-1:0]     now,
  input logic [edt_pkg::DUR_W-1:0]      duration,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [2:0]                     kind,
  input logic [edt_pkg::SLOT_W-1:0]     slot_out,
  input logic [edt_pkg::DUR_W-1:0]      remaining,
  input logic                           last
);
  import edt_pkg::*;

  `EDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(slot_out) && $stable(remaining) && $stable(last))
  `EDT_ASSERT_NOW(a_rem_only_nearest, out_valid && kind != KIND_NEAREST, remaining == '0)
  `EDT_ASSERT_NOW(a_slot_zero_empty, out_valid && (kind == KIND_NONE_EXPIRED || kind == KIND_NONE_ARMED), slot_out == '0)
  `EDT_ASSERT_NOW(a_single_is_last, out_valid && kind != KIND_EXPIRED, last)
  `EDT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind event_deadline_timer_table_top edt_checker u_edt_checker (.*);

>>> dv/testbench.sv
// Testbench for the event deadline timer table: queued requests checked against a slot-table predictor
`timescale 1ns / 1ps

module testbench;
  import edt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int MAX_RESULTS = 16;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 75;

  typedef struct {
    req_t              req;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    logic [DUR_W-1:0]  dur;
  } timer_word_t;

  typedef struct {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0]  rem;
    logic              last;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [LAZY_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        req_type = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic [TIME_W-1:0] now = '0;
  logic [DUR_W-1:0]  duration = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        kind;
  logic [SLOT_W-1:0] slot_out;
  logic [DUR_W-1:0]  remaining;
  logic              last;

  timer_word_t       pending_words[$];
  timer_result_t     due_results[$];
  logic              slot_armed [SLOTS];
  logic [TIME_W-1:0] slot_deadline [SLOTS];
  logic [TIME_W-1:0] planned_key [SLOTS];
  logic [LAZY_W-1:0] lazy_window = LAZY_RESET;
  logic [TIME_W-1:0] sched_ms = '0;
  logic              took_word = 1'b0;
  logic              quiet = 1'b0;
  int unsigned       idle_cycles = 0;
  int unsigned       errors = 0;

  event_deadline_timer_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .slot      (slot),
    .now       (now),
    .duration  (duration),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .slot_out  (slot_out),
    .remaining (remaining),
    .last      (last)
  );

  always #4 clk = ~clk;

  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_armed[i] && (best < 0 || slot_deadline[i] < slot_deadline[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void expect_result(kind_t k, int s, logic [DUR_W-1:0] rem, logic fin);
    timer_result_t r;
    r.kind = k;
    r.slot = SLOT_W'(s);
    r.rem = rem;
    r.last = fin;
    due_results.push_back(r);
  endfunction

  function automatic void predict_timer_results(timer_word_t w);
    int s;
    int b;
    int nxt;
    int n;
    logic fin;
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] mag;
    logic [TIME_W-1:0] gap;
    s = int'(w.slot) % SLOTS;
    n = 0;
    case (w.req)
      REQ_ADD: begin
        key = w.now + TIME_W'(w.dur);
        diff = key - slot_deadline[s];
        mag = diff[TIME_W-1] ? -diff : diff;
        if (slot_armed[s] && mag < TIME_W'(lazy_window)) begin
          expect_result(KIND_KEPT, s, '0, 1'b1);
        end else begin
          slot_deadline[s] = key;
          slot_armed[s] = 1'b1;
          expect_result(KIND_ADDED, s, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (slot_armed[s]) begin
          slot_armed[s] = 1'b0;
          expect_result(KIND_DELETED, s, '0, 1'b1);
        end else begin
          expect_result(KIND_DEL_IGNORED, s, '0, 1'b1);
        end
      end
      REQ_EXPIRE: begin
        b = earliest_armed();
        while (n < MAX_RESULTS && b >= 0 && slot_deadline[b] <= w.now) begin
          slot_armed[b] = 1'b0;
          n++;
          nxt = earliest_armed();
          fin = (n == MAX_RESULTS) || nxt < 0 || slot_deadline[nxt] > w.now;
          expect_result(KIND_EXPIRED, b, '0, fin);
          b = nxt;
        end
        if (n == 0) begin
          expect_result(KIND_NONE_EXPIRED, 0, '0, 1'b1);
        end
      end
      REQ_NEAREST: begin
        b = earliest_armed();
        if (b < 0) begin
          expect_result(KIND_NONE_ARMED, 0, '0, 1'b1);
        end else begin
          gap = slot_deadline[b] - w.now;
          expect_result(KIND_NEAREST, b,
                        (gap != 0 && !gap[TIME_W-1]) ? gap[DUR_W-1:0] : '0, 1'b1);
        end
      end
    endcase
  endfunction

  // Drive the request channel and the result stall
  always @(negedge clk) begin
    timer_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
      if (!in_valid || took_word) begin
        if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          req_type <= w.req;
          slot <= w.slot;
          now <= w.now;
          duration <= w.dur;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    timer_word_t w;
    timer_result_t r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_armed[i] = 1'b0;
        slot_deadline[i] = '0;
      end
      lazy_window = LAZY_RESET;
      took_word <= 1'b0;
      idle_cycles <= 0;
    end else begin
      took_word <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        w.req = req_t'(req_type);
        w.slot = slot;
        w.now = now;
        w.dur = duration;
        predict_timer_results(w);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          if (errors < MAX_REPORTS) begin
            $display("unexpected result word: kind %0d slot %0d remaining %0d last %0d",
                     kind, slot_out, remaining, last);
          end
          errors++;
        end else begin
          r = due_results.pop_front();
          if (kind !== r.kind || slot_out !== r.slot || remaining !== r.rem || last !== r.last) begin
            if (errors < MAX_REPORTS) begin
              $display("result mismatch: expected kind %0d slot %0d remaining %0d last %0d, got kind %0d slot %0d remaining %0d last %0d",
                       r.kind, r.slot, r.rem, r.last, kind, slot_out, remaining, last);
            end
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic void send(req_t r, int s, logic [TIME_W-1:0] t, logic [DUR_W-1:0] d);
    timer_word_t w;
    w.req = r;
    w.slot = SLOT_W'(s);
    w.now = t;
    w.dur = d;
    pending_words.push_back(w);
  endfunction

  task automatic settle();
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_lazy(logic [LAZY_W-1:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    lazy_window = v;
    @(posedge clk);
  endtask

  task automatic queue_directed();
    send(REQ_NEAREST, 0, 0, 0);
    send(REQ_EXPIRE, 0, 0, 0);
    send(REQ_DELETE, 5, 0, 0);
    send(REQ_ADD, 0, 0, 100);
    send(REQ_ADD, 0, 0, 150);
    send(REQ_ADD, 0, 0, 400);
    send(REQ_ADD, 15, '1, '1);
    send(REQ_ADD, 15, 32'hFFFF_FFFE, 0);
    send(REQ_ADD, 7, 100, 300);
    send(REQ_NEAREST, 0, 100, 0);
    send(REQ_NEAREST, 0, 500, 0);
    send(REQ_NEAREST, 0, 400, 0);
    send(REQ_ADD, 3, 10, 0);
    send(REQ_EXPIRE, 0, 400, 0);
    send(REQ_DELETE, 7, 0, 0);
    send(REQ_ADD, 7, 0, 5);
    send(REQ_DELETE, 7, 0, 0);
    send(REQ_EXPIRE, 0, '1, 0);
    send(REQ_ADD, 9, 0, '1);
    send(REQ_NEAREST, 0, 0, 0);
    send(REQ_DELETE, 9, 0, 0);
    send(REQ_DELETE, 9, 0, 0);
    send(REQ_NEAREST, 0, 0, 0);
  endtask

  task automatic queue_random_phase(int count);
    int i;
    int s;
    int pick;
    int span;
    int delta;
    logic [DUR_W-1:0] d;
    span = int'(lazy_window) + 4;
    // fill every slot, then flush the whole table at the latest time
    for (s = 0; s < SLOTS; s++) begin
      d = DUR_W'($urandom_range(0, 500));
      send(REQ_ADD, s, sched_ms, d);
      planned_key[s] = sched_ms + TIME_W'(d);
    end
    send(REQ_EXPIRE, $urandom_range(SLOTS - 1), '1, DUR_W'($urandom));
    for (i = SLOTS + 1; i < count; i++) begin
      pick = $urandom_range(99);
      s = $urandom_range(SLOTS - 1);
      if (pick < 30) begin
        d = DUR_W'($urandom_range(0, 3000));
        send(REQ_ADD, s, sched_ms, d);
        planned_key[s] = sched_ms + TIME_W'(d);
      end else if (pick < 45) begin
        if ($urandom_range(1)) begin
          delta = int'(lazy_window) - int'($urandom_range(0, 1));
        end else begin
          delta = int'($urandom_range(0, 2 * span)) - span;
        end
        if ($urandom_range(1)) begin
          delta = -delta;
        end
        d = DUR_W'(planned_key[s] - sched_ms + TIME_W'(delta));
        send(REQ_ADD, s, sched_ms, d);
      end else if (pick < 58) begin
        send(REQ_DELETE, s, $urandom, DUR_W'($urandom));
      end else if (pick < 75) begin
        sched_ms = sched_ms + TIME_W'($urandom_range(0, 1500));
        send(REQ_EXPIRE, s, sched_ms, DUR_W'($urandom));
      end else if (pick < 88) begin
        send(REQ_NEAREST, s, sched_ms + TIME_W'($urandom_range(0, 200)), DUR_W'($urandom));
      end else begin
        send(req_t'($urandom_range(3)), s, $urandom, DUR_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [LAZY_W-1:0] lazy_plan [PHASES];
    lazy_plan = '{16'd0, 16'hFFFF, 16'd1, LAZY_W'($urandom_range(2, 65534)), LAZY_RESET,
                  LAZY_W'($urandom_range(10, 3000))};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    queue_directed();
    settle();
    for (int p = 0; p < PHASES; p++) begin
      write_lazy(lazy_plan[p]);
      quiet = (p == 2);
      sched_ms = (p == 3) ? 32'hFFFF_F000 : TIME_W'($urandom_range(0, 1000000));
      queue_random_phase(PHASE_WORDS);
      settle();
    end
    quiet = 1'b0;
    repeat (40) @(negedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("event_deadline_timer_table_top test passed");
    end else begin
      $display("event_deadline_timer_table_top test failed");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("event_deadline_timer_table_top test failed");
    $finish;
  end

endmodule
